>>> rtl/sensor_frame_crc_decoder_unit_defines.svh
// Assertion helpers shared by the frame decoder RTL.
`ifndef SENSOR_FRAME_CRC_DECODER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_CRC_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define SFCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define SFCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sfcd_pkg.sv
package sfcd_pkg;

   typedef logic [3:0] pos_type;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REV  = 16'hA001;
   localparam pos_type     POS_IDLE      = 4'd8;
   localparam pos_type     PAYLOAD_END   = 4'd6;
   localparam pos_type     POS_CRC_HIGH  = 4'd7;
   localparam logic [15:0] TEMP_RESET    = 16'd400;
   localparam logic [15:0] HUMID_RESET   = 16'd300;

   // CRC-16/MODBUS over one byte, LSB first, unrolled eight bit steps
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/sfcd_req_if.sv
interface sfcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

>>> rtl/sfcd_rsp_if.sv
interface sfcd_rsp_if;
   logic               valid;
   logic               ready;
   logic               crc_match;
   logic signed [15:0] temperature_tenths;
   logic        [15:0] humidity_tenths;

   modport source (output valid, output crc_match, output temperature_tenths,
                   output humidity_tenths, input ready);
   modport sink   (input valid, input crc_match, input temperature_tenths,
                   input humidity_tenths, output ready);
endinterface

>>> rtl/sensor_frame_crc_decoder_unit.sv
// The result transfer for a frame is valid in the cycle after byte 7 is accepted.
// Throughput: 1 byte per cycle; the single result register stalls input only while
//   a finished result waits and the sink holds rsp ready low.
// Reset (synchronous, active high): CRC to 0xFFFF, byte position idle until a start,
//   held temperature 40.0 degrees, held humidity 30.0 percent, no result pending.
`include "sensor_frame_crc_decoder_unit_defines.svh"

module sensor_frame_crc_decoder_unit (
   input  logic     clock,
   input  logic     reset,
   sfcd_req_if.sink   req_chan,
   sfcd_rsp_if.source rsp_chan
);

   // Frame tracking state
   sfcd_pkg::pos_type pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;
   logic [31:0]       payload_ff, payload_in;
   logic [7:0]        crc_low_ff, crc_low_in;

   // Last good decoded values
   logic [15:0]       temp_ff, temp_in;
   logic [15:0]       humid_ff, humid_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              match_ff, match_in;
   logic [15:0]       rsp_temp_ff, rsp_temp_in;
   logic [15:0]       rsp_humid_ff, rsp_humid_in;

   logic              req_xfer;
   logic              rsp_xfer;
   sfcd_pkg::pos_type pos_eff;
   logic [15:0]       crc_eff;
   logic [15:0]       rx_crc;
   logic [14:0]       magnitude;
   logic              frame_done;

   // Take a new byte whenever the result register is empty or draining this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_valid_ff && rsp_chan.ready;

   // A start flag restarts the frame at byte 0 with a fresh CRC
   assign pos_eff    = req_chan.frame_start ? 4'd0 : pos_ff;
   assign crc_eff    = req_chan.frame_start ? sfcd_pkg::CRC_INIT : crc_ff;
   assign rx_crc     = {req_chan.rx_byte, crc_low_ff};
   assign magnitude  = {payload_ff[14:8], payload_ff[7:0]};
   assign frame_done = req_xfer && (pos_eff == sfcd_pkg::POS_CRC_HIGH);

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      payload_in = payload_ff;
      crc_low_in = crc_low_ff;
      temp_in    = temp_ff;
      humid_in   = humid_ff;
      match_in   = match_ff;

      if (req_xfer) begin
         crc_in = crc_eff;
         if (pos_eff < sfcd_pkg::PAYLOAD_END) begin
            // Payload byte: fold into the CRC, shift into the payload window
            crc_in     = sfcd_pkg::crc_feed(crc_eff, req_chan.rx_byte);
            payload_in = {payload_ff[23:0], req_chan.rx_byte};
            pos_in     = pos_eff + 4'd1;
         end else if (pos_eff == sfcd_pkg::PAYLOAD_END) begin
            // Low byte of the received CRC
            crc_low_in = req_chan.rx_byte;
            pos_in     = sfcd_pkg::POS_CRC_HIGH;
         end else if (pos_eff == sfcd_pkg::POS_CRC_HIGH) begin
            // High byte: compare and, on a match, decode the payload window
            match_in = (rx_crc == crc_eff);
            if (rx_crc == crc_eff) begin
               humid_in = payload_ff[31:16];
               // Sign-magnitude to two's complement; negative zero stays zero
               temp_in  = payload_ff[15] ? (16'd0 - {1'b0, magnitude}) : {1'b0, magnitude};
            end
            pos_in = sfcd_pkg::POS_IDLE;
         end
      end
   end

   // Load the result register on byte 7, drop it once the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_humid_in = rsp_humid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in  = temp_in;
         rsp_humid_in = humid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= sfcd_pkg::POS_IDLE;
         crc_ff       <= sfcd_pkg::CRC_INIT;
         temp_ff      <= sfcd_pkg::TEMP_RESET;
         humid_ff     <= sfcd_pkg::HUMID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_ff      <= temp_in;
         humid_ff     <= humid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and result data need no reset
   always_ff @(posedge clock) begin
      payload_ff   <= payload_in;
      crc_low_ff   <= crc_low_in;
      match_ff     <= match_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_humid_ff <= rsp_humid_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.crc_match          = match_ff;
   assign rsp_chan.temperature_tenths = $signed(rsp_temp_ff);
   assign rsp_chan.humidity_tenths    = rsp_humid_ff;

   // Hold input while a result waits on a stalled sink
   `SFCD_ASSERT_NOW(a_stall_blocks_input, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready,
      "input accepted while result register is stalled")
   // Byte 7 of a running frame always yields a result
   `SFCD_ASSERT_NEXT(a_byte7_gives_result,
      req_xfer && !req_chan.frame_start && pos_ff == sfcd_pkg::POS_CRC_HIGH,
      rsp_valid_ff && pos_ff == sfcd_pkg::POS_IDLE, "byte 7 transfer did not yield a result")
   // Bytes outside a frame change nothing
   `SFCD_ASSERT_NEXT(a_idle_ignores_bytes,
      req_xfer && !req_chan.frame_start && pos_ff == sfcd_pkg::POS_IDLE,
      pos_ff == sfcd_pkg::POS_IDLE && $stable(crc_ff) && $stable(temp_ff),
      "byte outside a frame changed frame state")
   // Position never passes the idle code
   `SFCD_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= sfcd_pkg::POS_IDLE,
      "byte position out of range")

endmodule
